[rtl/mnrc_pkg.sv]
// ----------------------------------------------------------------------------
// mnrc_pkg
// Shared types, codes and helpers of the multi-node response combiner.
// ----------------------------------------------------------------------------
package mnrc_pkg;

   // command codes carried in tuser
   localparam logic [1:0] CMD_BODY     = 2'd0;
   localparam logic [1:0] CMD_END      = 2'd1;
   localparam logic [1:0] CMD_VALIDATE = 2'd2;

   // result status codes
   localparam logic [2:0] STATUS_OK         = 3'd0;
   localparam logic [2:0] STATUS_IGNORED    = 3'd1;
   localparam logic [2:0] STATUS_BAD_KIND   = 3'd2;
   localparam logic [2:0] STATUS_MISMATCH   = 3'd3;
   localparam logic [2:0] STATUS_UNEXPECTED = 3'd4;

   // forward decisions
   localparam logic [1:0] FWD_DROP       = 2'd0;
   localparam logic [1:0] FWD_AS_IS      = 2'd1;
   localparam logic [1:0] FWD_COMPLETION = 2'd2;

   // request kinds
   localparam logic [2:0] KIND_NONE     = 3'd0;
   localparam logic [2:0] KIND_COMMAND  = 3'd1;
   localparam logic [2:0] KIND_QUERY    = 3'd2;
   localparam logic [2:0] KIND_COPY_IN  = 3'd3;
   localparam logic [2:0] KIND_COPY_OUT = 3'd4;

   // row count combining modes
   localparam logic [1:0] MODE_NONE  = 2'd0;
   localparam logic [1:0] MODE_EQUAL = 2'd1;
   localparam logic [1:0] MODE_SUM   = 2'd2;

   // register indexes
   localparam logic [1:0] CSR_NODE_TOTAL     = 2'd0;
   localparam logic [1:0] CSR_COUNT_MODE     = 2'd1;
   localparam logic [1:0] CSR_FORWARD_ENABLE = 2'd2;

   // message type codes
   localparam logic [7:0] MSG_COPY_DONE  = 8'h63; // c
   localparam logic [7:0] MSG_COMPLETE   = 8'h43; // C
   localparam logic [7:0] MSG_ROW_DESC   = 8'h54; // T
   localparam logic [7:0] MSG_PARAM      = 8'h53; // S
   localparam logic [7:0] MSG_COPY_IN    = 8'h47; // G
   localparam logic [7:0] MSG_COPY_OUT   = 8'h48; // H
   localparam logic [7:0] MSG_COPY_DATA  = 8'h64; // d
   localparam logic [7:0] MSG_DATA_ROW   = 8'h44; // D
   localparam logic [7:0] MSG_ERROR      = 8'h45; // E
   localparam logic [7:0] MSG_NOTIFY     = 8'h41; // A
   localparam logic [7:0] MSG_NOTICE     = 8'h4E; // N
   localparam logic [7:0] MSG_EMPTY      = 8'h49; // I

   localparam logic [7:0] CHAR_ZERO = 8'h30;
   localparam logic [7:0] CHAR_NINE = 8'h39;

   localparam logic [6:0] CNT_MAX = 7'd127;
   localparam logic [7:0] LEN_MAX = 8'd255;

   typedef struct packed {
      logic [7:0] body_byte;
      logic [7:0] type_code;
      logic [1:0] cmd;
   } req_type;

   typedef struct packed {
      logic [2:0]  request_kind;
      logic        request_valid;
      logic [7:0]  tag_digits;
      logic [31:0] combined_count;
      logic [1:0]  forward;
      logic [2:0]  status;
   } rsp_type;

   typedef struct packed {
      logic [6:0] node_total;
      logic [1:0] count_mode;
      logic       forward_enable;
   } cfg_type;

   function automatic logic [6:0] sat_inc(input logic [6:0] c);
      return (c == CNT_MAX) ? c : c + 7'd1;
   endfunction

endpackage

[rtl/mnrc_in_reg.sv]
// ----------------------------------------------------------------------------
// mnrc_in_reg
// Input register: captures one request transfer and holds it until the
// engine and result register take it.
// ----------------------------------------------------------------------------
module mnrc_in_reg (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  mnrc_pkg::req_type in_item,
   output logic              out_valid,
   input  logic              out_ready,
   output mnrc_pkg::req_type out_item
);
   import mnrc_pkg::*;

   logic    valid_ff, valid_in;
   req_type item_ff;

   assign in_ready  = !valid_ff || out_ready;
   assign valid_in  = in_ready ? in_valid : valid_ff;
   assign out_valid = valid_ff;
   assign out_item  = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         item_ff <= in_item;
      end
   end

endmodule

[rtl/mnrc_engine.sv]
// ----------------------------------------------------------------------------
// mnrc_engine
// Request state and per-item decision logic: digit run tracking, kind lock,
// per-kind counters, row count combining and the forward decision.
// ----------------------------------------------------------------------------
module mnrc_engine (
   input  logic              clock,
   input  logic              reset,
   input  logic              go,
   input  mnrc_pkg::req_type item,
   input  mnrc_pkg::cfg_type cfg,
   input  logic              mode_wr,
   output mnrc_pkg::rsp_type result
);
   import mnrc_pkg::*;

   logic        err_ff, err_step, err_in;
   logic [2:0]  kind_ff, kind_step, kind_in;
   logic [6:0]  cc_ff, cc_step, cc_in;
   logic [6:0]  desc_ff, desc_step, desc_in;
   logic [6:0]  cin_ff, cin_step, cin_in;
   logic [6:0]  cout_ff, cout_step, cout_in;
   logic [31:0] row_ff, row_step, row_in;
   logic [31:0] dv_ff, dv_step, dv_in;
   logic [7:0]  dl_ff, dl_step, dl_in;
   logic        co_ff, co_step, co_in;

   logic        is_digit;
   logic [35:0] dv_times10;
   logic [32:0] row_sum;
   logic [1:0]  mode_base, mode_eff;
   logic [1:0]  fwd_en;
   logic        complete;
   logic        do_clear;
   logic [2:0]  status;
   logic [1:0]  forward;
   logic [7:0]  tag;

   assign is_digit   = (item.body_byte >= CHAR_ZERO) && (item.body_byte <= CHAR_NINE);
   assign dv_times10 = {1'b0, dv_ff, 3'b000} + {3'b000, dv_ff, 1'b0}
                     + {28'd0, item.body_byte - CHAR_ZERO};
   assign row_sum    = {1'b0, row_ff} + {1'b0, dv_ff};
   assign mode_base  = (co_ff || cfg.count_mode > MODE_SUM) ? MODE_NONE : cfg.count_mode;
   assign fwd_en     = cfg.forward_enable ? FWD_AS_IS : FWD_DROP;

   always_comb begin
      complete = !err_ff && (kind_ff != KIND_NONE);
      if ((kind_ff == KIND_COMMAND || kind_ff == KIND_QUERY) && cc_ff != cfg.node_total)
         complete = 1'b0;
      if (kind_ff == KIND_QUERY && desc_ff != cfg.node_total)
         complete = 1'b0;
      if (kind_ff == KIND_COPY_IN && cin_ff != cfg.node_total)
         complete = 1'b0;
      if (kind_ff == KIND_COPY_OUT && cout_ff != cfg.node_total)
         complete = 1'b0;
   end

   always_comb begin
      err_step  = err_ff;
      kind_step = kind_ff;
      cc_step   = cc_ff;
      desc_step = desc_ff;
      cin_step  = cin_ff;
      cout_step = cout_ff;
      row_step  = row_ff;
      dv_step   = dv_ff;
      dl_step   = dl_ff;
      co_step   = co_ff;
      mode_eff  = mode_base;
      status    = STATUS_OK;
      forward   = FWD_DROP;
      tag       = dl_ff;
      do_clear  = 1'b0;
      if (go) begin
         unique case (item.cmd)
            CMD_BODY: begin
               if (is_digit) begin
                  dv_step = (dv_times10[35:32] != 4'd0) ? 32'hFFFF_FFFF : dv_times10[31:0];
                  dl_step = (dl_ff == LEN_MAX) ? dl_ff : dl_ff + 8'd1;
               end else begin
                  dv_step = '0;
                  dl_step = '0;
               end
               tag = dl_step;
            end
            CMD_END: begin
               dv_step = '0;
               dl_step = '0;
               if (err_ff) begin
                  status = STATUS_IGNORED;
               end else begin
                  unique case (item.type_code) inside
                     MSG_COPY_DONE, MSG_COPY_OUT, MSG_COPY_DATA: begin
                        if (kind_ff != KIND_NONE && kind_ff != KIND_COPY_OUT) begin
                           status = STATUS_BAD_KIND;
                        end else begin
                           kind_step = KIND_COPY_OUT;
                           if (item.type_code == MSG_COPY_DATA)
                              forward = fwd_en;
                           else
                              cout_step = sat_inc(cout_ff);
                        end
                     end
                     MSG_ROW_DESC, MSG_PARAM: begin
                        if (kind_ff != KIND_NONE && kind_ff != KIND_QUERY) begin
                           status = STATUS_BAD_KIND;
                        end else begin
                           kind_step = KIND_QUERY;
                           desc_step = sat_inc(desc_ff);
                           if (item.type_code == MSG_ROW_DESC ? desc_ff == 7'd0
                                                              : desc_step == cfg.node_total)
                              forward = fwd_en;
                        end
                     end
                     MSG_COPY_IN: begin
                        if (kind_ff != KIND_NONE && kind_ff != KIND_COPY_IN) begin
                           status = STATUS_BAD_KIND;
                        end else begin
                           kind_step = KIND_COPY_IN;
                           cin_step  = sat_inc(cin_ff);
                           if (cin_ff == 7'd0)
                              forward = fwd_en;
                        end
                     end
                     MSG_COMPLETE: begin
                        if (mode_base == MODE_EQUAL && dl_ff != 8'd0 && cc_ff != 7'd0
                            && dv_ff != row_ff) begin
                           status = STATUS_MISMATCH;
                        end else begin
                           if (kind_ff == KIND_NONE)
                              kind_step = KIND_COMMAND;
                           if (mode_base != MODE_NONE) begin
                              if (dl_ff == 8'd0) begin
                                 co_step  = 1'b1;
                                 mode_eff = MODE_NONE;
                              end else if (mode_base == MODE_EQUAL) begin
                                 if (cc_ff == 7'd0)
                                    row_step = dv_ff;
                              end else begin
                                 row_step = row_sum[32] ? 32'hFFFF_FFFF : row_sum[31:0];
                              end
                           end
                           cc_step = sat_inc(cc_ff);
                           if (cc_step == cfg.node_total && cfg.forward_enable)
                              forward = (mode_eff == MODE_NONE) ? FWD_AS_IS : FWD_COMPLETION;
                        end
                     end
                     MSG_ERROR: begin
                        err_step = 1'b1;
                        forward  = fwd_en;
                     end
                     MSG_DATA_ROW, MSG_NOTIFY, MSG_NOTICE: begin
                        forward = fwd_en;
                     end
                     default: begin
                        status = STATUS_UNEXPECTED;
                     end
                  endcase
               end
            end
            CMD_VALIDATE: begin
               do_clear = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   assign err_in  = do_clear ? 1'b0 : err_step;
   assign kind_in = do_clear ? KIND_NONE : kind_step;
   assign cc_in   = do_clear ? 7'd0 : cc_step;
   assign desc_in = do_clear ? 7'd0 : desc_step;
   assign cin_in  = do_clear ? 7'd0 : cin_step;
   assign cout_in = do_clear ? 7'd0 : cout_step;
   assign row_in  = do_clear ? 32'd0 : row_step;
   assign dv_in   = do_clear ? 32'd0 : dv_step;
   assign dl_in   = do_clear ? 8'd0 : dl_step;
   assign co_in   = mode_wr ? 1'b0 : co_step;

   assign result.status         = status;
   assign result.forward        = forward;
   assign result.combined_count = row_step;
   assign result.tag_digits     = tag;
   assign result.request_valid  = do_clear && complete;
   assign result.request_kind   = kind_step;

   always_ff @(posedge clock) begin
      if (reset) begin
         err_ff  <= 1'b0;
         kind_ff <= KIND_NONE;
         cc_ff   <= '0;
         desc_ff <= '0;
         cin_ff  <= '0;
         cout_ff <= '0;
         row_ff  <= '0;
         dv_ff   <= '0;
         dl_ff   <= '0;
         co_ff   <= 1'b0;
      end else begin
         err_ff  <= err_in;
         kind_ff <= kind_in;
         cc_ff   <= cc_in;
         desc_ff <= desc_in;
         cin_ff  <= cin_in;
         cout_ff <= cout_in;
         row_ff  <= row_in;
         dv_ff   <= dv_in;
         dl_ff   <= dl_in;
         co_ff   <= co_in;
      end
   end

endmodule

[rtl/mnrc_out_reg.sv]
// ----------------------------------------------------------------------------
// mnrc_out_reg
// Result register: holds one result until the downstream side takes it,
// and reloads in the same cycle when it does.
// ----------------------------------------------------------------------------
module mnrc_out_reg (
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   output logic              can_load,
   input  mnrc_pkg::rsp_type in_result,
   output logic              out_valid,
   input  logic              out_ready,
   output mnrc_pkg::rsp_type out_result
);
   import mnrc_pkg::*;

   logic    valid_ff, valid_in;
   rsp_type result_ff;

   assign can_load   = !valid_ff || out_ready;
   assign valid_in   = load || (valid_ff && !out_ready);
   assign out_valid  = valid_ff;
   assign out_result = result_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= in_result;
      end
   end

endmodule

[rtl/multi_node_response_combiner.sv]
// ----------------------------------------------------------------------------
// multi_node_response_combiner
// Merges reply messages from several nodes: tracks the trailing digit run,
// locks the request kind, counts per kind, combines row counts and decides
// what to forward.
//
//   channel  dir  handshake          payload
//   req_     in   tvalid/tready      tuser cmd, tdata type_code/body_byte
//   rsp_     out  tvalid/tready      tdata result fields
//   csr_     in   we (no wait)       index, wdata
//
// One transfer per cycle in and out while rsp_ does not stall; a request reaches
// rsp_ through the input register, then the result register.
// All request state sits in the engine and updates as the item leaves the
// input register; reset clears it.
// A stalled rsp_ side holds both registers; req_tready drops only when both
// are full.
// ----------------------------------------------------------------------------
module multi_node_response_combiner (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [1:0]  req_tuser,   // cmd
   input  logic [15:0] req_tdata,   // type_code, body_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // status, forward, combined_count, tag_digits,
                                    // request_valid, request_kind
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [6:0]  csr_wdata
);
   import mnrc_pkg::*;

   cfg_type cfg_ff, cfg_in;
   logic    mode_wr;
   req_type req_item, eng_item;
   rsp_type eng_result, rsp_result;
   logic    eng_valid, out_can_load, go;

   assign req_item.cmd       = req_tuser;
   assign req_item.type_code = req_tdata[7:0];
   assign req_item.body_byte = req_tdata[15:8];

   always_comb begin
      cfg_in  = cfg_ff;
      mode_wr = 1'b0;
      if (csr_we) begin
         unique case (csr_index)
            CSR_NODE_TOTAL:     cfg_in.node_total = csr_wdata;
            CSR_COUNT_MODE: begin
               cfg_in.count_mode = csr_wdata[1:0];
               mode_wr           = 1'b1;
            end
            CSR_FORWARD_ENABLE: cfg_in.forward_enable = csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.node_total     <= 7'd1;
         cfg_ff.count_mode     <= MODE_NONE;
         cfg_ff.forward_enable <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign go = eng_valid && out_can_load;

   mnrc_in_reg u_in_reg (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_item   (req_item),
      .out_valid (eng_valid),
      .out_ready (out_can_load),
      .out_item  (eng_item)
   );

   mnrc_engine u_engine (
      .clock   (clock),
      .reset   (reset),
      .go      (go),
      .item    (eng_item),
      .cfg     (cfg_ff),
      .mode_wr (mode_wr),
      .result  (eng_result)
   );

   mnrc_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .load       (go),
      .can_load   (out_can_load),
      .in_result  (eng_result),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_result (rsp_result)
   );

   assign rsp_tdata = {7'd0, rsp_result};

endmodule

[tb/sv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the multi-node response combiner. A short directed
// sequence covers every message type, the byte extremes and the odd command.
// After that, phases under different register settings run randomized reply
// sequences from the nodes, mostly well formed, some broken, plus noise. Each
// request transfer is run through a cycle-free predictor. Every result
// transfer is compared field by field with the oldest prediction. The sender
// idles in bursts and the receiver stalls on a rolling mask.
// ----------------------------------------------------------------------------
module testbench;

   import mnrc_pkg::*;

   localparam logic [1:0] MODE_UNUSED = 2'd3;

   typedef struct packed {
      logic [1:0] cmd;
      logic [7:0] mtype;
      logic [7:0] body;
   } reply_item_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [1:0]  req_tuser = '0;
   logic [15:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [6:0]  csr_wdata = '0;

   multi_node_response_combiner u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // pending request transfers and predicted results
   reply_item_type reply_in_q[$];
   rsp_type        reply_due_q[$];

   // predictor copy of registers and request state
   logic [6:0]  nodes_cfg;
   logic [1:0]  mode_cfg;
   logic        fwd_cfg;
   logic        lat_err;
   logic [2:0]  kind_now;
   logic [6:0]  n_complete;
   logic [6:0]  n_desc;
   logic [6:0]  n_cin;
   logic [6:0]  n_cout;
   logic [31:0] rows_sum;
   logic [31:0] run_value;
   logic [7:0]  run_len;
   logic        combine_off;

   int          fault_count = 0;
   int          rsp_count = 0;
   bit          req_moved = 1'b0;
   int          burst_left = 1;
   int          gap_left = 0;
   logic [15:0] ready_mask = '1;
   logic [5:0]  ready_pos = '0;
   rsp_type     seen;
   rsp_type     wanted;
   rsp_type     predicted;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #3_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   task automatic report_error(input string msg);
      $display("ERROR: %s", msg);
      fault_count++;
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want)
         report_error($sformatf("result %0d %s: got %0h, expected %0h",
                                rsp_count, name, got, want));
   endtask

   task automatic combine_reply(input logic [1:0] cmd, input logic [7:0] mtype,
                                input logic [7:0] b, output rsp_type r);
      logic [31:0] d;
      logic [6:0]  old;
      logic [1:0]  mode;
      logic [1:0]  fw;
      logic        ok;
      r = '0;
      r.tag_digits = run_len;
      fw = fwd_cfg ? FWD_AS_IS : FWD_DROP;
      case (cmd)
         CMD_BODY: begin
            if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
               d = 32'(b - CHAR_ZERO);
               if (run_value > (32'hFFFF_FFFF - d) / 10)
                  run_value = '1;
               else
                  run_value = run_value * 10 + d;
               if (run_len != LEN_MAX)
                  run_len++;
            end else begin
               run_value = '0;
               run_len = '0;
            end
            r.tag_digits = run_len;
         end
         CMD_END: begin
            if (lat_err) begin
               r.status = STATUS_IGNORED;
            end else begin
               case (mtype)
                  MSG_COPY_DONE, MSG_COPY_OUT, MSG_COPY_DATA: begin
                     if (kind_now != KIND_NONE && kind_now != KIND_COPY_OUT) begin
                        r.status = STATUS_BAD_KIND;
                     end else begin
                        kind_now = KIND_COPY_OUT;
                        if (mtype == MSG_COPY_DATA)
                           r.forward = fw;
                        else if (n_cout != CNT_MAX)
                           n_cout++;
                     end
                  end
                  MSG_ROW_DESC, MSG_PARAM: begin
                     if (kind_now != KIND_NONE && kind_now != KIND_QUERY) begin
                        r.status = STATUS_BAD_KIND;
                     end else begin
                        kind_now = KIND_QUERY;
                        old = n_desc;
                        if (n_desc != CNT_MAX)
                           n_desc++;
                        if (mtype == MSG_ROW_DESC ? old == 0 : n_desc == nodes_cfg)
                           r.forward = fw;
                     end
                  end
                  MSG_COPY_IN: begin
                     if (kind_now != KIND_NONE && kind_now != KIND_COPY_IN) begin
                        r.status = STATUS_BAD_KIND;
                     end else begin
                        kind_now = KIND_COPY_IN;
                        old = n_cin;
                        if (n_cin != CNT_MAX)
                           n_cin++;
                        if (old == 0)
                           r.forward = fw;
                     end
                  end
                  MSG_COMPLETE: begin
                     mode = (combine_off || mode_cfg > MODE_SUM) ? MODE_NONE : mode_cfg;
                     if (mode == MODE_EQUAL && run_len != 0 && n_complete != 0 &&
                         run_value != rows_sum) begin
                        r.status = STATUS_MISMATCH;
                     end else begin
                        if (kind_now == KIND_NONE)
                           kind_now = KIND_COMMAND;
                        if (mode != MODE_NONE) begin
                           if (run_len == 0) begin
                              combine_off = 1'b1;
                              mode = MODE_NONE;
                           end else if (mode == MODE_EQUAL) begin
                              if (n_complete == 0)
                                 rows_sum = run_value;
                           end else begin
                              rows_sum = (rows_sum > 32'hFFFF_FFFF - run_value) ?
                                         '1 : rows_sum + run_value;
                           end
                        end
                        if (n_complete != CNT_MAX)
                           n_complete++;
                        if (n_complete == nodes_cfg && fwd_cfg)
                           r.forward = (mode == MODE_NONE) ? FWD_AS_IS : FWD_COMPLETION;
                     end
                  end
                  MSG_ERROR: begin
                     lat_err = 1'b1;
                     r.forward = fw;
                  end
                  MSG_DATA_ROW, MSG_NOTIFY, MSG_NOTICE: begin
                     r.forward = fw;
                  end
                  default: begin
                     r.status = STATUS_UNEXPECTED;
                  end
               endcase
            end
            run_value = '0;
            run_len = '0;
         end
         default: begin
         end
      endcase
      r.combined_count = rows_sum;
      r.request_kind = kind_now;
      if (cmd == CMD_VALIDATE) begin
         ok = !lat_err && kind_now != KIND_NONE;
         if ((kind_now == KIND_COMMAND || kind_now == KIND_QUERY) && n_complete != nodes_cfg)
            ok = 1'b0;
         if (kind_now == KIND_QUERY && n_desc != nodes_cfg)
            ok = 1'b0;
         if (kind_now == KIND_COPY_IN && n_cin != nodes_cfg)
            ok = 1'b0;
         if (kind_now == KIND_COPY_OUT && n_cout != nodes_cfg)
            ok = 1'b0;
         r.request_valid = ok;
         lat_err = 1'b0;
         kind_now = KIND_NONE;
         n_complete = '0;
         n_desc = '0;
         n_cin = '0;
         n_cout = '0;
         rows_sum = '0;
         run_value = '0;
         run_len = '0;
      end
   endtask

   task automatic add_item(input logic [1:0] cmd, input logic [7:0] mtype,
                           input logic [7:0] body);
      reply_item_type it;
      it.cmd = cmd;
      it.mtype = mtype;
      it.body = body;
      reply_in_q.push_back(it);
   endtask

   // random prefix bytes, optional run of nines, optional decimal count, end
   task automatic add_message(input logic [7:0] t, input bit with_count,
                              input logic [31:0] val, input bit terse, input int pad9);
      logic [7:0]  digs [0:9];
      logic [31:0] v;
      int          n;
      if (!terse)
         repeat ($urandom_range(0, 3)) add_item(CMD_BODY, 8'($urandom), 8'($urandom));
      repeat (pad9) add_item(CMD_BODY, 8'($urandom), CHAR_NINE);
      if (with_count) begin
         v = val;
         n = 0;
         do begin
            digs[n] = CHAR_ZERO + 8'(v % 10);
            v = v / 10;
            n++;
         end while (v != 0);
         while (n > 0) begin
            n--;
            add_item(CMD_BODY, 8'($urandom), digs[n]);
         end
      end
      add_item(CMD_END, t, 8'($urandom));
   endtask

   function automatic logic [31:0] some_rows();
      case ($urandom_range(0, 3))
         0: return '0;
         1: return $urandom_range(1, 999);
         2: return $urandom;
         default: return 32'hFFFF_FFFF - $urandom_range(0, 7);
      endcase
   endfunction

   function automatic logic [7:0] any_type();
      case ($urandom_range(0, 12))
         0: return MSG_COPY_DONE;
         1: return MSG_COMPLETE;
         2: return MSG_ROW_DESC;
         3: return MSG_PARAM;
         4: return MSG_COPY_IN;
         5: return MSG_COPY_OUT;
         6: return MSG_COPY_DATA;
         7: return MSG_DATA_ROW;
         8: return MSG_ERROR;
         9: return MSG_NOTIFY;
         10: return MSG_NOTICE;
         11: return MSG_EMPTY;
         default: return 8'($urandom);
      endcase
   endfunction

   // one request: a reply set from the nodes, then usually a validate
   task automatic gen_request();
      int          replies;
      int          scen;
      int          i;
      logic [31:0] rows;
      logic [31:0] val;
      bit          terse;
      replies = (nodes_cfg == 0) ? 2 : nodes_cfg;
      terse = (replies > 8);
      if (replies > 100) begin
         // drives the copy-out counter into saturation
         repeat (replies + 3) add_message(MSG_COPY_DONE, 1'b0, '0, 1'b1, 0);
         add_item(CMD_VALIDATE, 8'($urandom), 8'($urandom));
         return;
      end
      if (!terse && $urandom_range(0, 5) == 0)
         replies = $urandom_range(0, 1) ? replies + 1 : replies - 1;
      scen = terse ? 0 : $urandom_range(0, 9);
      rows = some_rows();
      for (i = 0; i < replies; i++) begin
         case (scen)
            0, 1, 2, 3: begin
               if (!terse && $urandom_range(0, 3) == 0)
                  add_message(MSG_DATA_ROW, 1'b0, '0, 1'b0, 0);
               val = (mode_cfg == MODE_SUM) ? some_rows() : rows;
               if (terse)
                  val = $urandom_range(0, 9);
               else if ($urandom_range(0, 7) == 0)
                  val = val + $urandom_range(1, 9);
               add_message(MSG_COMPLETE, $urandom_range(0, 11) != 0, val, terse,
                           ($urandom_range(0, 24) == 0) ? 11 : 0);
            end
            4, 5: begin
               add_message($urandom_range(0, 1) ? MSG_ROW_DESC : MSG_PARAM,
                           1'b0, '0, 1'b0, 0);
               repeat ($urandom_range(0, 2))
                  add_message(MSG_DATA_ROW, 1'($urandom_range(0, 1)), $urandom, 1'b0, 0);
               add_message(MSG_COMPLETE, 1'b1, rows, 1'b0, 0);
            end
            6: begin
               add_message(MSG_COPY_IN, 1'b0, '0, 1'b0, 0);
               if ($urandom_range(0, 2) == 0)
                  add_message(MSG_NOTICE, 1'b0, '0, 1'b0, 0);
            end
            7: begin
               repeat ($urandom_range(0, 2))
                  add_message(MSG_COPY_DATA, 1'($urandom_range(0, 1)), $urandom, 1'b0, 0);
               add_message($urandom_range(0, 1) ? MSG_COPY_OUT : MSG_COPY_DONE,
                           1'($urandom_range(0, 1)), $urandom, 1'b0, 0);
            end
            8: begin
               add_message((i == replies / 2) ? MSG_ERROR : any_type(),
                           1'($urandom_range(0, 1)), $urandom, 1'b0, 0);
            end
            default: begin
               repeat ($urandom_range(1, 3))
                  add_item(2'($urandom_range(0, 3)), 8'($urandom), 8'($urandom));
            end
         endcase
      end
      if (!terse && $urandom_range(0, 5) == 0)
         add_message(any_type(), 1'($urandom_range(0, 1)), some_rows(), 1'b0, 0);
      if (terse || $urandom_range(0, 9) != 0)
         add_item(CMD_VALIDATE, 8'($urandom), 8'($urandom));
   endtask

   task automatic set_reg(input logic [1:0] idx, input logic [6:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_NODE_TOTAL: nodes_cfg = val;
         CSR_COUNT_MODE: begin
            mode_cfg = val[1:0];
            combine_off = 1'b0;
         end
         CSR_FORWARD_ENABLE: fwd_cfg = val[0];
         default: begin
         end
      endcase
      @(negedge clock);
   endtask

   task automatic settle();
      while (reply_in_q.size() != 0 || reply_due_q.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic run_phase(input logic [6:0] nodes, input logic [1:0] mode,
                            input logic fwd, input int budget);
      settle();
      set_reg(CSR_NODE_TOTAL, nodes);
      set_reg(CSR_COUNT_MODE, {5'd0, mode});
      set_reg(CSR_FORWARD_ENABLE, {6'd0, fwd});
      csr_we <= 1'b0;
      @(posedge clock);
      while (reply_in_q.size() < budget) gen_request();
   endtask

   // sender and receiver
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         rsp_tready <= 1'b0;
      end else begin
         if (!req_tvalid || req_moved) begin
            if (req_moved) begin
               req_moved = 1'b0;
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(1, 24);
                  gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
               end
            end
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (reply_in_q.size() > 0) begin
               req_tvalid <= 1'b1;
               req_tuser <= reply_in_q[0].cmd;
               req_tdata <= {reply_in_q[0].body, reply_in_q[0].mtype};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
         if (ready_pos == 0) begin
            case ($urandom_range(0, 3))
               0: ready_mask = '1;
               1: ready_mask = 16'($urandom);
               2: ready_mask = 16'($urandom | $urandom);
               default: ready_mask = 16'($urandom & $urandom);
            endcase
            if (ready_mask == 0)
               ready_mask = 16'h0001;
         end
         rsp_tready <= ready_mask[ready_pos[3:0]];
         ready_pos = ready_pos + 6'd1;
      end
   end

   // transfer monitor and checker
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            seen = rsp_type'(rsp_tdata[48:0]);
            if (reply_due_q.size() == 0) begin
               report_error($sformatf("result %0d with nothing outstanding: %0h",
                                      rsp_count, rsp_tdata));
            end else begin
               wanted = reply_due_q.pop_front();
               check_field("status", 32'(seen.status), 32'(wanted.status));
               check_field("forward", 32'(seen.forward), 32'(wanted.forward));
               check_field("combined_count", seen.combined_count, wanted.combined_count);
               check_field("tag_digits", 32'(seen.tag_digits), 32'(wanted.tag_digits));
               check_field("request_valid", 32'(seen.request_valid),
                           32'(wanted.request_valid));
               check_field("request_kind", 32'(seen.request_kind),
                           32'(wanted.request_kind));
            end
            rsp_count++;
         end
         if (req_tvalid && req_tready) begin
            combine_reply(req_tuser, req_tdata[7:0], req_tdata[15:8], predicted);
            reply_due_q.push_back(predicted);
            void'(reply_in_q.pop_front());
            req_moved = 1'b1;
         end
      end
   end

   initial begin
      nodes_cfg = 7'd1;
      mode_cfg = MODE_NONE;
      fwd_cfg = 1'b1;
      combine_off = 1'b0;
      lat_err = 1'b0;
      kind_now = KIND_NONE;
      n_complete = '0;
      n_desc = '0;
      n_cin = '0;
      n_cout = '0;
      rows_sum = '0;
      run_value = '0;
      run_len = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // byte extremes, digit run, every type, kind conflicts, error latch
      add_item(CMD_BODY, 8'h00, 8'h00);
      add_item(CMD_BODY, 8'hFF, 8'hFF);
      add_item(CMD_BODY, 8'h00, CHAR_ZERO);
      add_item(CMD_BODY, 8'h00, CHAR_NINE);
      add_item(CMD_END, MSG_COMPLETE, 8'h00);
      add_item(CMD_VALIDATE, 8'h00, 8'h00);
      add_item(CMD_END, MSG_ROW_DESC, 8'h00);
      add_item(CMD_END, MSG_PARAM, 8'h00);
      add_item(CMD_END, MSG_COMPLETE, 8'h00);
      add_item(CMD_VALIDATE, 8'h00, 8'h00);
      add_item(CMD_END, MSG_COPY_IN, 8'h00);
      add_item(CMD_END, MSG_ROW_DESC, 8'h00);
      add_item(CMD_END, MSG_EMPTY, 8'h00);
      add_item(CMD_VALIDATE, 8'h00, 8'h00);
      add_item(CMD_END, MSG_COPY_DATA, 8'h00);
      add_item(CMD_END, MSG_COPY_OUT, 8'h00);
      add_item(CMD_END, MSG_COPY_DONE, 8'h00);
      add_item(CMD_VALIDATE, 8'h00, 8'h00);
      add_item(CMD_END, MSG_ERROR, 8'h00);
      add_item(CMD_END, MSG_DATA_ROW, 8'h00);
      add_item(CMD_VALIDATE, 8'h00, 8'h00);
      add_item(CMD_END, MSG_NOTIFY, 8'h00);
      add_item(CMD_END, MSG_NOTICE, 8'h00);
      add_item(2'd3, 8'hFF, 8'hFF);
      add_item(CMD_VALIDATE, 8'hFF, 8'hFF);

      run_phase(7'd2, MODE_EQUAL, 1'b1, 12);
      // digit run long enough to saturate both value and length
      add_message(MSG_COMPLETE, 1'b1, 32'd42, 1'b0, 258);
      add_item(CMD_VALIDATE, 8'h00, 8'h00);
      run_phase(7'd3, MODE_SUM, 1'b1, 12);
      run_phase(7'd1, MODE_SUM, 1'b0, 12);
      run_phase(7'd4, MODE_EQUAL, 1'b0, 12);
      run_phase(7'd10, MODE_NONE, 1'b1, 1);
      run_phase(7'd127, MODE_UNUSED, 1'b1, 1);
      run_phase(7'd0, MODE_SUM, 1'b1, 12);
      run_phase(7'd2, MODE_SUM, 1'b1, 12);
      run_phase(7'd5, MODE_EQUAL, 1'b1, 12);
      run_phase(7'd3, MODE_NONE, 1'b0, 12);
      run_phase(7'd1, MODE_EQUAL, 1'b1, 12);

      settle();
      if (fault_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
